[src/shk_pkg.sv]
// ----------------------------------------------------------------------------
// Shake detector package
// Item types, register indexes, reset values and sequencer states shared by
// the shake detector modules.
// ----------------------------------------------------------------------------
package shk_pkg;

	// Field widths fixed by the item formats.
	localparam int AXIS_W = 16;
	localparam int TIME_W = 32;
	localparam int MAG_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// Default number of low bits used from each axis.
	localparam int SAMPLE_BITS_DEF = 16;
	// Default radicand width: three squares of SAMPLE_BITS_DEF bits.
	localparam int SUM_W_DEF = 2 * SAMPLE_BITS_DEF + 2;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD    = 2'd1;
	localparam logic [IDX_W-1:0] REG_COOLDOWN  = 2'd2;

	// Register and state reset values.
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd5734;
	localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd25;
	localparam logic [CFG_W-1:0] COOLDOWN_RST  = 16'd800;
	localparam logic [MAG_W-1:0] PREV_MAG_RST  = 16'd16384;

	// Axis select codes for the squaring pass.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// One input item: a three-axis sample and its timestamp.
	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic [TIME_W-1:0]        sample_time_ms;
	} sample_t;

	// One result item.
	typedef struct packed {
		logic             sample_taken;
		logic             shake_detected;
		logic [MAG_W-1:0] magnitude;
		logic [MAG_W-1:0] magnitude_change;
	} result_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SQUARE = 4'b0010,
		ST_ROOT   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

[src/shake_detector_unit.sv]
// ----------------------------------------------------------------------------
// Shake detector unit
// Flags shakes from the change of the accelerometer vector magnitude.
// ----------------------------------------------------------------------------
// Usage:
// Input items (in_valid/in_ready, in_item) carry a three-axis sample and a
// millisecond timestamp. Every input item yields exactly one result item on
// out_valid/out_ready, out_item, in order.
// A sample that comes sooner than sample_period_ms after the last taken one
// yields an all-zero result without going through the squarer or the root.
// A taken sample is squared axis by axis on one multiplier, then its magnitude
// is found by the iterative square root at one bit per cycle, then compared
// and stored.
// The block works on one item at a time; in_ready is high only when idle.
// The result sits in an output register, so the next item is accepted while
// a result still waits; if the receiver stalls longer, the finished item
// waits in the last step until the output register is free.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once; users
// must make them while idle, which the block does not enforce. Reset restores
// the default registers, a previous magnitude of one g and zero timestamps.
// ----------------------------------------------------------------------------
module shake_detector_unit #(
	parameter int SAMPLE_BITS = shk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  shk_pkg::sample_t          in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output shk_pkg::result_t          out_item,
	input  logic                      cfg_we,
	input  logic [shk_pkg::IDX_W-1:0] cfg_idx,
	input  logic [shk_pkg::CFG_W-1:0] cfg_data
);
	import shk_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int SQ_W   = 2 * SB;
	localparam int SUM_W  = 2 * SB + 2;
	localparam int ROOT_W = SUM_W / 2;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0] threshold_q;
	logic [CFG_W-1:0] period_q;
	logic [CFG_W-1:0] cooldown_q;

	// Detector state.
	logic [MAG_W-1:0]  prev_mag_q;
	logic [TIME_W-1:0] last_acc_q;
	logic [TIME_W-1:0] last_trig_q;

	// Working registers for the current item.
	sample_t          item_q;
	logic             taken_q;
	logic [1:0]       axis_q;
	logic [SUM_W-1:0] acc_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	logic              accept;
	logic [TIME_W-1:0] since_acc;
	logic [TIME_W-1:0] since_trig;
	logic              gate_pass;
	logic [SB-1:0]     axis_raw;
	logic [SB-1:0]     axis_abs;
	logic [SQ_W-1:0]   sq;
	logic [SUM_W-1:0]  sum_next;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] root;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  delta;
	logic              shake;
	logic              out_free;
	logic              out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// Period gate on wrapping timestamp differences.
	always_comb begin
		since_acc = in_item.sample_time_ms - last_acc_q;
		gate_pass = !(since_acc < TIME_W'(period_q));
	end

	// Shared squarer: absolute value of the selected axis, squared and added.
	always_comb begin
		case (axis_q)
			AXIS_X:  axis_raw = item_q.accel_x[SB-1:0];
			AXIS_Y:  axis_raw = item_q.accel_y[SB-1:0];
			default: axis_raw = item_q.accel_z[SB-1:0];
		endcase
		axis_abs = axis_raw[SB-1] ? (~axis_raw + SB'(1)) : axis_raw;
		sq       = {{SB{1'b0}}, axis_abs} * {{SB{1'b0}}, axis_abs};
		sum_next = acc_q + SUM_W'(sq);
	end

	assign sqrt_start = (state_q == ST_SQUARE) && (axis_q == AXIS_Z);

	shk_sqrt #(
		.IN_W(SUM_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_next),
		.done     (sqrt_done),
		.root     (root)
	);

	// Change of magnitude and the trigger decision for a finished item.
	always_comb begin
		since_trig = item_q.sample_time_ms - last_trig_q;
		mag        = taken_q ? MAG_W'(root) : '0;
		if (!taken_q) begin
			delta = '0;
		end else if (mag >= prev_mag_q) begin
			delta = mag - prev_mag_q;
		end else begin
			delta = prev_mag_q - mag;
		end
		shake = taken_q && (delta > threshold_q) &&
			(since_trig > TIME_W'(cooldown_q));
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			period_q    <= PERIOD_RST;
			cooldown_q  <= COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_PERIOD:    period_q    <= cfg_data;
				REG_COOLDOWN:  cooldown_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_mag_q  <= PREV_MAG_RST;
			last_acc_q  <= '0;
			last_trig_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= gate_pass ? ST_SQUARE : ST_FINISH;
					end
				end
				ST_SQUARE: begin
					if (axis_q == AXIS_Z) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (taken_q) begin
							prev_mag_q <= mag;
							last_acc_q <= item_q.sample_time_ms;
						end
						if (shake) begin
							last_trig_q <= item_q.sample_time_ms;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item registers, accumulator and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= in_item;
			taken_q <= gate_pass;
			axis_q  <= AXIS_X;
			acc_q   <= '0;
		end else if (state_q == ST_SQUARE) begin
			axis_q <= axis_q + 2'd1;
			acc_q  <= sum_next;
		end
		if (out_load) begin
			out_q.sample_taken     <= taken_q;
			out_q.shake_detected   <= shake;
			out_q.magnitude        <= mag;
			out_q.magnitude_change <= delta;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[src/shk_sqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit restoring square root: one result bit per cycle from one
// shared compare and subtract. Gives the floor of the root.
// ----------------------------------------------------------------------------
module shk_sqrt #(
	parameter int IN_W = shk_pkg::SUM_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   radicand,
	output logic              done,
	output logic [IN_W/2-1:0] root
);
	import shk_pkg::*;

	localparam int ROOT_W = IN_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [IN_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// Bring down the next pair of radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[IN_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Control: busy while the root bits are found, done pulses after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: radicand shifter, partial remainder and partial root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[IN_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[src/shk_checker.sv]
// ----------------------------------------------------------------------------
// Shake detector port checker
// Watches the ports of the shake detector unit and flags inconsistent results
// and handshake slips.
// ----------------------------------------------------------------------------
module shk_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input shk_pkg::result_t out_item
);
	import shk_pkg::*;

	// A pending result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed or dropped while stalled");

	// The unit works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is still in work");

	// A shake is only reported on a taken sample with a nonzero change.
	a_shake_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.shake_detected |->
			out_item.sample_taken && (out_item.magnitude_change != '0))
		else $error("shake reported without a taken sample");

	// A skipped sample gives an all-zero result.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.sample_taken |->
			(out_item.magnitude == '0) && (out_item.magnitude_change == '0))
		else $error("skipped sample carries a magnitude");

endmodule

bind shake_detector_unit shk_checker u_shk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[tb/sv/shk_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Shake detector scoreboard
// Tracks the detector's configuration and state, predicts one result item
// for every sample item the block accepts, and checks the block's results
// against those predictions in order.
// ----------------------------------------------------------------------------
package shk_tb_pkg;

	import shk_pkg::*;

	class shake_scoreboard;
		// Mirror of the configuration registers.
		logic [CFG_W-1:0]  threshold;
		logic [CFG_W-1:0]  period_ms;
		logic [CFG_W-1:0]  holdoff_ms;
		// Mirror of the detector state.
		logic [MAG_W-1:0]  last_mag;
		logic [TIME_W-1:0] taken_ms;
		logic [TIME_W-1:0] trigger_ms;
		// Predicted results still waiting for the block.
		result_t           expected_q[$];
		int                mismatches;
		int                results_seen;

		function new();
			threshold    = THRESHOLD_RST;
			period_ms    = PERIOD_RST;
			holdoff_ms   = COOLDOWN_RST;
			last_mag     = PREV_MAG_RST;
			taken_ms     = '0;
			trigger_ms   = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_THRESHOLD: begin
					threshold = value;
				end
				REG_PERIOD: begin
					period_ms = value;
				end
				REG_COOLDOWN: begin
					holdoff_ms = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Absolute value of one axis, wide enough for the most negative code.
		static function logic [63:0] abs_axis(logic signed [AXIS_W-1:0] a);
			logic [63:0] wide;
			wide = {48'd0, a};
			if (a[AXIS_W-1]) begin
				wide = 64'h10000 - wide;
			end
			return wide;
		endfunction

		// Largest root whose square does not exceed the radicand, MSB first.
		static function logic [MAG_W-1:0] floor_root(logic [63:0] radicand);
			logic [63:0] root;
			logic [63:0] trial;
			root = '0;
			for (int b = MAG_W - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= radicand) begin
					root = trial;
				end
			end
			return root[MAG_W-1:0];
		endfunction

		// Predict the result of one accepted sample and advance the state.
		function void note_sample(sample_t s);
			result_t           r;
			logic [TIME_W-1:0] now;
			logic [63:0]       ax;
			logic [63:0]       ay;
			logic [63:0]       az;
			logic [MAG_W-1:0]  mag;
			r   = '0;
			now = s.sample_time_ms;
			if (now - taken_ms >= {16'd0, period_ms}) begin
				taken_ms = now;
				ax  = abs_axis(s.accel_x);
				ay  = abs_axis(s.accel_y);
				az  = abs_axis(s.accel_z);
				mag = floor_root(ax * ax + ay * ay + az * az);
				r.sample_taken     = 1'b1;
				r.magnitude        = mag;
				r.magnitude_change = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
				last_mag = mag;
				// A trigger needs a large change and the cooldown strictly passed.
				if (r.magnitude_change > threshold &&
				    now - trigger_ms > {16'd0, holdoff_ms}) begin
					r.shake_detected = 1'b1;
					trigger_ms = now;
				end
			end
			expected_q.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			$display("ERROR result %0d: %s", results_seen, msg);
			mismatches++;
		endtask

		// Compare one result item with the oldest prediction.
		task check_result(result_t r);
			result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				flag_mismatch("result arrived with no item outstanding");
				return;
			end
			e = expected_q.pop_front();
			if (r.sample_taken !== e.sample_taken) begin
				flag_mismatch($sformatf("sample_taken got %0b want %0b",
					r.sample_taken, e.sample_taken));
			end
			if (r.shake_detected !== e.shake_detected) begin
				flag_mismatch($sformatf("shake_detected got %0b want %0b",
					r.shake_detected, e.shake_detected));
			end
			if (r.magnitude !== e.magnitude) begin
				flag_mismatch($sformatf("magnitude got %0d want %0d",
					r.magnitude, e.magnitude));
			end
			if (r.magnitude_change !== e.magnitude_change) begin
				flag_mismatch($sformatf("magnitude_change got %0d want %0d",
					r.magnitude_change, e.magnitude_change));
			end
		endtask
	endclass

endpackage

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Shake detector unit testbench
// Drives directed corner samples and then random sample streams through
// several register settings, with random gaps on both handshakes and one long
// receiver hold-off, and checks every result item against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import shk_pkg::*;
	import shk_tb_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 30;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	sample_t           in_item;
	logic              out_valid;
	logic              out_ready;
	result_t           out_item;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	int                send_idle_pct;
	int                recv_idle_pct;
	logic              hold_req;
	int                stall_cycles = 0;
	int                random_sent;
	logic [TIME_W-1:0] now_ms;
	shake_scoreboard   sb = new();

	shake_detector_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both handshakes; values seen here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_sample(in_item);
		end
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_item);
		end
	end

	// Give up when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("shake_detector_unit verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one item and return at the edge where it is accepted.
	task automatic send_sample(input sample_t s);
		in_valid <= 1'b1;
		in_item  <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_axes(input logic signed [AXIS_W-1:0] x,
	                         input logic signed [AXIS_W-1:0] y,
	                         input logic signed [AXIS_W-1:0] z,
	                         input logic [TIME_W-1:0] t);
		sample_t s;
		s.accel_x        = x;
		s.accel_y        = y;
		s.accel_z        = z;
		s.sample_time_ms = t;
		send_sample(s);
	endtask

	// Write all three registers on consecutive edges; the block is idle here.
	task automatic write_config(input logic [CFG_W-1:0] thr,
	                            input logic [CFG_W-1:0] per,
	                            input logic [CFG_W-1:0] cool);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_idx  <= REG_PERIOD;
		cfg_data <= per;
		@(posedge clk);
		cfg_idx  <= REG_COOLDOWN;
		cfg_data <= cool;
		@(posedge clk);
		cfg_we   <= 1'b0;
		sb.write_reg(REG_THRESHOLD, thr);
		sb.write_reg(REG_PERIOD, per);
		sb.write_reg(REG_COOLDOWN, cool);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Next timestamp: mostly paced around the period and cooldown, sometimes
	// inside the period, repeated, or a jump anywhere in the 32-bit range.
	function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t,
	                                                input logic [CFG_W-1:0] per,
	                                                input logic [CFG_W-1:0] cool);
		case ($urandom_range(11))
			0: begin
				return $urandom;
			end
			1: begin
				return t;
			end
			2, 3: begin
				return t + $urandom_range(per);
			end
			default: begin
				return t + per + $urandom_range(cool / 2 + 10);
			end
		endcase
	endfunction

	// Random sample: a resting sensor half of the time, with violent motion,
	// corner codes and free fall mixed in.
	function automatic sample_t random_sample(input logic [TIME_W-1:0] t);
		sample_t     s;
		logic [15:0] corner[4];
		int          g;
		corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		s.accel_x = 16'(int'($urandom_range(1200)) - 600);
		s.accel_y = 16'(int'($urandom_range(1200)) - 600);
		s.accel_z = 16'(int'($urandom_range(1200)) - 600);
		s.sample_time_ms = t;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				g = $urandom_range(1) ? 16384 : -16384;
				g = g + int'($urandom_range(4000)) - 2000;
				case ($urandom_range(2))
					0: s.accel_x = 16'(g);
					1: s.accel_y = 16'(g);
					default: s.accel_z = 16'(g);
				endcase
			end
			5, 6, 7: begin
				s.accel_x = 16'($urandom);
				s.accel_y = 16'($urandom);
				s.accel_z = 16'($urandom);
			end
			8: begin
				s.accel_x = corner[$urandom_range(3)];
				s.accel_y = corner[$urandom_range(3)];
				s.accel_z = corner[$urandom_range(3)];
			end
			default: begin
				s.accel_x = '0;
				s.accel_y = '0;
				s.accel_z = '0;
			end
		endcase
		return s;
	endfunction

	// Random stream under the current settings; the idle mix follows the
	// overall random item count.
	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (random_sent < 250) begin
				send_idle_pct = 18;
				recv_idle_pct = 45;
			end else if (random_sent < 500) begin
				send_idle_pct = 45;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			now_ms = next_time(now_ms, sb.period_ms, sb.holdoff_ms);
			if ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			send_sample(random_sample(now_ms));
			random_sent++;
			// The sender keeps offering while the receiver holds off.
			if (random_sent == 120) begin
				hold_req = 1'b1;
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = REG_THRESHOLD;
		cfg_data      = '0;
		hold_req      = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_sent   = 0;
		now_ms        = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples under the reset settings.
		send_axes(16'sd16384, 16'sd0, 16'sd0, 32'd10);       // inside the period
		send_axes(16'sd0, 16'sd0, 16'sd16384, 32'd25);       // exactly one period later
		send_axes(16'sd32767, 16'sd32767, 16'sd32767, 32'd50); // large change, cooling down
		send_axes(16'sh8000, 16'sh8000, 16'sh8000, 32'd900); // largest vector
		send_axes(16'sd0, 16'sd0, 16'sd0, 32'd950);          // free fall triggers
		send_axes(16'sd0, 16'sd0, 16'sd0, 32'd1000);         // no change
		send_axes(16'sd16384, 16'sd0, 16'sd0, 32'd1750);     // cooldown exactly reached only
		send_axes(16'sd0, 16'sd0, 16'sd0, 32'd1800);         // cooldown passed
		send_axes(16'sd16384, 16'sd16384, 16'sd0, 32'd1810); // ignored inside the period
		send_axes(16'sd0, -16'sd16384, 16'sd0, 32'hFFFF_FFF0); // close to the timestamp wrap
		send_axes(16'sd0, 16'sd0, 16'sh8000, 32'h0000_0009); // period met across the wrap
		send_axes(16'sd27034, 16'sd0, 16'sd0, 32'h0000_0400); // change equal to the threshold
		send_axes(16'sd21299, 16'sd0, 16'sd0, 32'h0000_0420); // change one above the threshold
		send_axes(-16'sd12345, 16'sd23456, -16'sd3210, 32'h0000_0500);
		drain_results();

		// Zero period, cooldown and threshold.
		write_config('0, '0, '0);
		send_axes(16'sd1, 16'sd1, 16'sd1, 32'h0000_0500);    // same time as the last taken sample
		send_axes(-16'sd1, 16'sd1, -16'sd1, 32'h0000_0501);  // no change at all
		send_axes(16'sd0, 16'sd0, 16'sd2, 32'h0000_0501);    // one millisecond after a trigger
		send_axes(16'sd0, 16'sd0, 16'sd3, 32'h0000_0501);    // same millisecond again
		send_axes(16'sd0, -16'sd2, 16'sd0, 32'h0000_0501);
		drain_results();
		now_ms = 32'h0000_0600;

		// Random phases over several settings, the extremes among them.
		write_config(16'($urandom_range(3000, 9000)), 16'd25, 16'd800);
		run_random(250);
		drain_results();
		write_config('0, '0, '0);
		run_random(200);
		drain_results();
		write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(100);
		drain_results();
		write_config(16'($urandom_range(20000)), 16'($urandom_range(100)),
			16'($urandom_range(2000)));
		run_random(200);
		drain_results();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("shake_detector_unit verification clean");
		end else begin
			$display("shake_detector_unit verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
src/shk_pkg.sv
src/shk_sqrt.sv
src/shake_detector_unit.sv
src/shk_checker.sv
tb/sv/shk_tb_pkg.sv
tb/sv/tb_top.sv
